// ===== rtl/core/alt_pkg.sv =====
// ----------------------------------------------------------------------------
// alt_pkg: shared types and constants for the assembler line tokenizer
// Character codes, record layout and the front-to-back bundle format.
// ----------------------------------------------------------------------------
`default_nettype none

package alt_pkg;

  localparam int unsigned LINE_MAX_DEF = 256;

  // bundle queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic KIND_TOKEN = 1'b0;
  localparam logic KIND_EOL   = 1'b1;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_STRING  = 2'd2,
    MODE_IGNORE  = 2'd3
  } mode_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] start;
    logic [8:0] len;
    logic [8:0] idx;
  } rec_t;

  // up to three records caused by one character
  typedef struct packed {
    rec_t [2:0] recs;
    logic       too_long;
    logic [1:0] cnt;
  } bundle_t;

  function automatic rec_t mk_rec(input logic kind, input logic [7:0] start,
                                  input logic [8:0] len, input logic [8:0] idx);
    rec_t r;
    r.kind  = kind;
    r.start = start;
    r.len   = len;
    r.idx   = idx;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/assembler_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// assembler_line_tokenizer: streaming lexer for one assembler source line
// Reports token records (start, length, index) and an end-of-line record.
// ----------------------------------------------------------------------------
// One character is taken per cycle on the slave stream while the bundle queue
// is not full; tlast marks the last character of the line buffer. The front
// stage classifies the character and updates the line state in the same cycle,
// packing the zero to three records it causes into a bundle; a two-entry bundle
// queue decouples it from the back stage, which sends one record per cycle from
// a register while the master stream is ready. A character's bundle goes first
// into the queue, then into the back stage register that drives the master
// stream. Input sustains one character per cycle as long as records average at
// most one per character and the master stream is ready; the output port, at
// one record per cycle, sets the rate when they come denser. Spaces and tabs
// separate tokens, a comma is a token of its own, a quote opens a string through
// the next quote, and a newline outside a string closes the line, after which
// characters are dropped up to tlast. No clearing pass is needed after reset.
`default_nettype none

module assembler_line_tokenizer import alt_pkg::*; #(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  wire logic        s_axis_tlast_i,   // end_of_buffer
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [7:0] token_start, [16:8] token_length,
                                             // [25:17] token_index, [26] line_too_long
  output logic             m_axis_tuser_o,   // kind
  output logic             m_axis_tlast_o    // last_of_run
);

  bundle_t f_bundle, q_head;
  logic    f_push, q_full, q_valid, b_pop;
  rec_t    b_rec;
  logic    b_too_long;

  alt_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .ch_i     (s_axis_tdata_i),
    .eob_i    (s_axis_tlast_i),
    .push_o   (f_push),
    .bundle_o (f_bundle),
    .full_i   (q_full)
  );

  alt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_bundle),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .data_o  (q_head),
    .valid_o (q_valid)
  );

  alt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_valid_i (q_valid),
    .pop_o        (b_pop),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .rec_o        (b_rec),
    .too_long_o   (b_too_long),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'd0, b_too_long, b_rec.idx, b_rec.len, b_rec.start};
  assign m_axis_tuser_o = b_rec.kind;

endmodule

`default_nettype wire

// ===== rtl/core/alt_front.sv =====
// ----------------------------------------------------------------------------
// alt_front: character classifier and line state
// Updates the line state per character and emits a bundle of records.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_front import alt_pkg::*; #(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] ch_i,
  input  wire logic       eob_i,
  output logic            push_o,
  output bundle_t         bundle_o,
  input  wire logic       full_i
);

  localparam int unsigned PW = $clog2(LINE_MAX + 1);
  localparam int unsigned SW = $clog2(LINE_MAX);

  mode_e         mode_q, mode_d;
  logic [PW-1:0] position_q, position_d;
  logic [SW-1:0] ostart_q, ostart_d;
  logic [PW-1:0] olen_q, olen_d;
  logic [PW-1:0] tally_q, tally_d;
  logic          ovf_q, ovf_d;
  logic          fire;

  assign ready_o = !full_i;
  assign fire    = valid_i && !full_i;

  always_comb begin
    logic          sep;
    logic [SW-1:0] pos;
    logic [1:0]    n;
    bundle_t       b;

    sep        = (ch_i == CH_SPACE) || (ch_i == CH_TAB);
    n          = 2'd0;
    b          = '0;
    mode_d     = mode_q;
    ostart_d   = ostart_q;
    olen_d     = olen_q;
    tally_d    = tally_q;
    ovf_d      = ovf_q;
    position_d = position_q;

    if (position_q >= PW'(LINE_MAX)) begin
      ovf_d = 1'b1;
      pos   = SW'(LINE_MAX - 1);
    end else begin
      pos        = SW'(position_q);
      position_d = position_q + PW'(1);
    end

    case (mode_q)
      MODE_BETWEEN: begin
        if (sep) begin
          mode_d = MODE_BETWEEN;
        end else if (ch_i == CH_NL) begin
          b.recs[n] = mk_rec(KIND_EOL, 8'd0, 9'd0, 9'(tally_d));
          n         = n + 2'd1;
          mode_d    = MODE_IGNORE;
        end else if (ch_i == CH_COMMA) begin
          b.recs[n] = mk_rec(KIND_TOKEN, 8'(pos), 9'd1, 9'(tally_d));
          n         = n + 2'd1;
          if (tally_d < PW'(LINE_MAX)) tally_d = tally_d + PW'(1);
        end else begin
          ostart_d = pos;
          olen_d   = PW'(1);
          mode_d   = (ch_i == CH_QUOTE) ? MODE_STRING : MODE_WORD;
        end
      end
      MODE_WORD: begin
        if (sep || ch_i == CH_COMMA || ch_i == CH_NL) begin
          b.recs[n] = mk_rec(KIND_TOKEN, 8'(ostart_q), 9'(olen_q), 9'(tally_d));
          n         = n + 2'd1;
          if (tally_d < PW'(LINE_MAX)) tally_d = tally_d + PW'(1);
          mode_d = MODE_BETWEEN;
          if (ch_i == CH_COMMA) begin
            b.recs[n] = mk_rec(KIND_TOKEN, 8'(pos), 9'd1, 9'(tally_d));
            n         = n + 2'd1;
            if (tally_d < PW'(LINE_MAX)) tally_d = tally_d + PW'(1);
          end else if (ch_i == CH_NL) begin
            b.recs[n] = mk_rec(KIND_EOL, 8'd0, 9'd0, 9'(tally_d));
            n         = n + 2'd1;
            mode_d    = MODE_IGNORE;
          end
        end else if (olen_q < PW'(LINE_MAX)) begin
          olen_d = olen_q + PW'(1);
        end
      end
      MODE_STRING: begin
        if (olen_q < PW'(LINE_MAX)) olen_d = olen_q + PW'(1);
        if (ch_i == CH_QUOTE) begin
          b.recs[n] = mk_rec(KIND_TOKEN, 8'(ostart_q), 9'(olen_d), 9'(tally_d));
          n         = n + 2'd1;
          if (tally_d < PW'(LINE_MAX)) tally_d = tally_d + PW'(1);
          mode_d = MODE_BETWEEN;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase

    if (eob_i) begin
      // flush any open token, then close the line
      if (mode_d == MODE_WORD || mode_d == MODE_STRING) begin
        b.recs[n] = mk_rec(KIND_TOKEN, 8'(ostart_d), 9'(olen_d), 9'(tally_d));
        n         = n + 2'd1;
        if (tally_d < PW'(LINE_MAX)) tally_d = tally_d + PW'(1);
      end
      if (mode_d != MODE_IGNORE) begin
        b.recs[n] = mk_rec(KIND_EOL, 8'd0, 9'd0, 9'(tally_d));
        n         = n + 2'd1;
      end
    end

    b.too_long = ovf_d;
    b.cnt      = n;
    bundle_o   = b;
    push_o     = fire && (n != 2'd0);

    if (eob_i) begin
      mode_d     = MODE_BETWEEN;
      position_d = '0;
      ostart_d   = '0;
      olen_d     = '0;
      tally_d    = '0;
      ovf_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_BETWEEN;
      position_q <= '0;
      ostart_q   <= '0;
      olen_q     <= '0;
      tally_q    <= '0;
      ovf_q      <= 1'b0;
    end else if (fire) begin
      mode_q     <= mode_d;
      position_q <= position_d;
      ostart_q   <= ostart_d;
      olen_q     <= olen_d;
      tally_q    <= tally_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/alt_queue.sv =====
// ----------------------------------------------------------------------------
// alt_queue: bundle queue
// Small FIFO of record bundles between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_queue import alt_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire bundle_t data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output bundle_t      data_o,
  output logic         valid_o
);

  bundle_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_q, rd_q;
  logic [QUEUE_CW-1:0]   cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + QUEUE_CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QUEUE_CW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/alt_back.sv =====
// ----------------------------------------------------------------------------
// alt_back: record serializer
// Holds one bundle and sends its records one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_back import alt_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire bundle_t head_i,
  input  wire logic    head_valid_i,
  output logic         pop_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output rec_t         rec_o,
  output logic         too_long_o,
  output logic         last_o
);

  bundle_t    bundle_q;
  logic [1:0] sel_q;
  logic       busy_q;
  logic       fire;

  assign valid_o    = busy_q;
  assign rec_o      = bundle_q.recs[sel_q];
  assign too_long_o = bundle_q.too_long;
  assign last_o     = (sel_q == bundle_q.cnt - 2'd1);
  assign fire       = busy_q && ready_i;
  assign pop_o      = head_valid_i && (!busy_q || (fire && last_o));

  always_ff @(posedge clk_i) begin
    if (pop_o) bundle_q <= head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= '0;
      busy_q <= 1'b0;
    end else if (pop_o) begin
      sel_q  <= '0;
      busy_q <= 1'b1;
    end else if (fire) begin
      if (last_o) busy_q <= 1'b0;
      else        sel_q  <= sel_q + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/alt_checker.sv =====
// ----------------------------------------------------------------------------
// alt_checker: port-level checks for the tokenizer
// Output stream protocol and record shape.
// ----------------------------------------------------------------------------
`default_nettype none

module alt_checker import alt_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // stalled transaction stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  // end-of-line records carry zero start and length
  a_eol_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_EOL |-> m_axis_tdata_o[16:0] == 17'd0)
    else $error("end-of-line record with nonzero start or length");

  // nothing follows an end-of-line record within one character's records
  a_eol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_EOL |-> m_axis_tlast_o)
    else $error("end-of-line record not last of its run");

  // a token always has at least one character
  a_tok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_TOKEN |-> m_axis_tdata_o[16:8] != 9'd0)
    else $error("token record with zero length");

endmodule

bind assembler_line_tokenizer alt_checker u_alt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the assembler line tokenizer
// Feeds source lines one character per transaction, predicts the token and
// end-of-line records in a scoreboard and checks every record field by field.
// ----------------------------------------------------------------------------

module tb_top;
  import alt_pkg::*;

  // One expected record as it should leave the master stream.
  typedef struct {
    logic       kind;
    logic [7:0] start;
    logic [8:0] len;
    logic [8:0] idx;
    logic       too_long;
    logic       last;
  } token_rec_t;

  // One character transaction for the slave stream.
  typedef struct {
    logic [7:0] ch;
    logic       eob;
  } char_item_t;

  // Line tokenizer prediction plus the queue of records still to arrive.
  class line_token_board;
    token_rec_t  expected_q[$];
    mode_e       mode;
    logic [8:0]  col;
    logic [7:0]  open_start;
    logic [8:0]  open_len;
    logic [8:0]  tally;
    logic        too_long;
    int unsigned errors;
    int unsigned chars_seen;
    int unsigned lines_seen;
    int unsigned long_lines;
    int unsigned records_checked;

    function new();
      clear_line();
    endfunction

    function void clear_line();
      mode       = MODE_BETWEEN;
      col        = '0;
      open_start = '0;
      open_len   = '0;
      tally      = '0;
      too_long   = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push_rec(logic kind, logic [7:0] start, logic [8:0] len, logic [8:0] idx);
      token_rec_t r;
      r.kind     = kind;
      r.start    = start;
      r.len      = len;
      r.idx      = idx;
      r.too_long = too_long;
      r.last     = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void push_token(logic [7:0] start, logic [8:0] len);
      push_rec(KIND_TOKEN, start, len, tally);
      if (tally < LINE_MAX_DEF) tally++;
    endfunction

    function void grow_token();
      if (open_len < LINE_MAX_DEF) open_len++;
    endfunction

    // Accepted character: work out the records it causes.
    function void note_char(logic [7:0] ch, logic eob);
      logic       sep;
      logic [7:0] pos;
      int         n_before;
      token_rec_t r;
      n_before = expected_q.size();
      sep = (ch == CH_SPACE) || (ch == CH_TAB);
      chars_seen++;
      // past the buffer size every character sits on the last slot
      if (col >= LINE_MAX_DEF) begin
        too_long = 1'b1;
        pos = 8'(LINE_MAX_DEF - 1);
      end else begin
        pos = col[7:0];
        col++;
      end
      case (mode)
        MODE_BETWEEN: begin
          if (sep) begin
          end else if (ch == CH_NL) begin
            push_rec(KIND_EOL, '0, '0, tally);
            mode = MODE_IGNORE;
          end else if (ch == CH_COMMA) begin
            push_token(pos, 9'd1);
          end else begin
            open_start = pos;
            open_len   = 9'd1;
            mode = (ch == CH_QUOTE) ? MODE_STRING : MODE_WORD;
          end
        end
        MODE_WORD: begin
          if (sep || ch == CH_COMMA || ch == CH_NL) begin
            push_token(open_start, open_len);
            mode = MODE_BETWEEN;
            if (ch == CH_COMMA) begin
              push_token(pos, 9'd1);
            end else if (ch == CH_NL) begin
              push_rec(KIND_EOL, '0, '0, tally);
              mode = MODE_IGNORE;
            end
          end else begin
            grow_token();
          end
        end
        MODE_STRING: begin
          grow_token();
          if (ch == CH_QUOTE) begin
            push_token(open_start, open_len);
            mode = MODE_BETWEEN;
          end
        end
        default: begin
        end
      endcase
      if (eob) begin
        if (mode == MODE_WORD || mode == MODE_STRING) push_token(open_start, open_len);
        if (mode != MODE_IGNORE) push_rec(KIND_EOL, '0, '0, tally);
        lines_seen++;
        if (too_long) long_lines++;
        clear_line();
      end
      if (expected_q.size() > n_before) begin
        r = expected_q.pop_back();
        r.last = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      end
    endfunction

    // Accepted record: compare against the oldest expectation.
    function void check_record(logic [31:0] data, logic kind, logic last);
      token_rec_t want;
      records_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("record with nothing pending: tdata %h tuser %b tlast %b", data, kind, last);
        return;
      end
      want = expected_q.pop_front();
      compare("kind", 32'(want.kind), 32'(kind));
      compare("token_start", 32'(want.start), 32'(data[7:0]));
      compare("token_length", 32'(want.len), 32'(data[16:8]));
      compare("token_index", 32'(want.idx), 32'(data[25:17]));
      compare("line_too_long", 32'(want.too_long), 32'(data[26]));
      compare("last_of_run", 32'(want.last), 32'(last));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  line_token_board board;
  char_item_t      char_items[$];

  always #1 clk_i = ~clk_i;

  assembler_line_tokenizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  // Mostly back-to-back, now and then a short gap, rarely a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_char(logic [7:0] c);
    char_item_t it;
    it.ch  = c;
    it.eob = 1'b0;
    char_items.push_back(it);
  endfunction

  // Put the end-of-buffer mark on the character queued last.
  function automatic void close_line();
    char_item_t it;
    it = char_items.pop_back();
    it.eob = 1'b1;
    char_items.push_back(it);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    close_line();
  endfunction

  // Any byte that is not a separator, comma, newline or quote.
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_COMMA || c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] string_char();
    case ($urandom_range(0, 5))
      0:       return CH_NL;
      1:       return CH_SPACE;
      2:       return CH_COMMA;
      default: return word_char();
    endcase
  endfunction

  // Well-formed line with random content; about one in ten is raw noise.
  function automatic void add_random_line();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 5))
          0, 1: repeat ($urandom_range(1, 5)) add_char(word_char());
          2:    add_char(CH_COMMA);
          3:    repeat ($urandom_range(1, 2)) add_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
          4: begin
            add_char(CH_QUOTE);
            repeat ($urandom_range(0, 4)) add_char(string_char());
            if ($urandom_range(0, 3) != 0) add_char(CH_QUOTE);
          end
          default: begin
            repeat ($urandom_range(1, 3)) add_char(word_char());
            add_char(CH_SPACE);
          end
        endcase
      end
      // newline with trailing junk, or the buffer simply ends
      if ($urandom_range(0, 1) == 0) begin
        add_char(CH_NL);
        repeat ($urandom_range(0, 3)) add_char(8'($urandom_range(0, 255)));
      end
    end
    close_line();
  endfunction

  function automatic void build_stimulus();
    // comma and newline right after a word, ignored tail
    add_text("ab,c d\nx");
    // string holding a newline, then comma, tab, buffer ends inside a word
    add_text("\"s\nq\",\tw");
    // buffer ends inside an open string
    add_text("\"op");
    // buffer ends on the newline itself
    add_text("\n");
    // empty line
    add_text(" ");
    // extreme byte values as a word, then comma and end of buffer together
    add_char(8'h00);
    add_char(8'hFF);
    add_char(CH_COMMA);
    close_line();
    while (char_items.size() < 130) add_random_line();
  endfunction

  // Slave side: one character per transaction, random gaps in between.
  task automatic drive_chars();
    int gap;
    foreach (char_items[i]) begin
      gap = idle_len();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= char_items[i].ch;
      s_tlast  <= char_items[i].eob;
      do @(posedge clk_i); while (!s_tready);
      board.note_char(char_items[i].ch, char_items[i].eob);
    end
    s_tvalid <= 1'b0;
  endtask

  // Master side: random back-pressure, with one long hold-off so the
  // bundle queue fills and the input stalls.
  initial begin : sink
    int rounds;
    int hold;
    rounds = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      rounds++;
      hold = (rounds == 12) ? 80 : idle_len();
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Every accepted record transaction goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) board.check_record(m_tdata, m_tuser, m_tlast);
  end

  initial begin : main
    board = new();
    build_stimulus();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    drive_chars();
    while (board.pending() != 0) @(posedge clk_i);
    // catch any stray record after the last expected one
    repeat (10) @(posedge clk_i);
    $display("Run: %0d characters on %0d lines, %0d records checked, %0d errors.",
             board.chars_seen, board.lines_seen, board.records_checked, board.errors);
    $display("Covered words, strings, commas, newlines, ignored tails; %0d overlong lines.",
             board.long_lines);
    if (board.errors == 0) begin
      $display("** assembler_line_tokenizer: PASSED **");
    end else begin
      $display("** assembler_line_tokenizer: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #1000000;
    $display("Timeout with %0d records still pending.", board.pending());
    $display("** assembler_line_tokenizer: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/alt_pkg.sv
rtl/core/alt_front.sv
rtl/core/alt_queue.sv
rtl/core/alt_back.sv
rtl/core/assembler_line_tokenizer.sv
rtl/core/alt_checker.sv
dv/tb_top.sv
